// File: hw/rtl/gbq_pkg.sv
// gbq_pkg: shared types, codes and constants of the gain bucket priority queue
// no dependencies; imported by gain_bucket_priority_queue and its bench
`timescale 1ns / 1ps
package gbq_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int MAX_BUCKETS = 32;
  localparam int NODE_W = 10;
  localparam int LINK_W = 11;
  localparam int BKT_W = 5;
  localparam int ROW_W = 5;
  localparam int ROWS = 32;
  localparam int COUNT_W = 11;
  localparam int GAIN_W = 16;
  localparam int MAXG_W = 15;
  localparam int DIV_W = 21;

  typedef logic [LINK_W-1:0] link_t;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_POP = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [NODE_W-1:0] node;
    logic signed [GAIN_W-1:0] gain;
  } gbq_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] popped_node;
    logic [1:0] status;
    logic [COUNT_W-1:0] count;
  } gbq_out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DIV_LOAD, S_DIV_RUN, S_ROUTE,
    S_DETACH, S_PUSH_A, S_PUSH_B, S_SETTLE, S_DONE
  } gbq_state_t;

  // link value of the sentinel that heads bucket b
  function automatic link_t sent_code(input logic [BKT_W-1:0] b);
    sent_code = {1'b1, {(LINK_W-1-BKT_W){1'b0}}, b};
  endfunction

endpackage

// File: hw/rtl/gain_bucket_priority_queue.sv
// gain_bucket_priority_queue: bucketed LIFO priority queue over node ids
// depends on gbq_pkg (types, command and status codes, sentinel encoding)
`timescale 1ns / 1ps
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+--------------------------------
// in      | in        | in_valid / in_stall | gbq_in_t  (cmd, node, gain)
// out     | out       | out_valid/out_stall | gbq_out_t (popped_node,status,count)
// cfg     | in        | cfg_valid/cfg_ready | max_gain, 15 bits
//
// one transaction at a time under a small sequencer; remove, pop and update may walk
// the top marker down past empty buckets
// bucket index from one shared 21-bit compare/subtract unit: 5 steps, none if 2m+1 <= 32
// reset, a clear command and a max_gain write run a pass over the presence rows
// during which in_stall stays high; cfg_ready is always high
// a finished result waits in the output register while the next transaction is taken
module gain_bucket_priority_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gbq_pkg::gbq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gbq_pkg::gbq_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [14:0]       cfg_data
);
  import gbq_pkg::*;

  gbq_state_t state, state_next;

  // latched request
  logic [2:0]               op;
  logic [NODE_W-1:0]        req_node;
  logic signed [GAIN_W-1:0] req_gain;

  // working registers
  logic [NODE_W-1:0]        nd;
  logic [BKT_W-1:0]         sb, ob, top;
  logic                     top_live;
  logic                     phase_old;
  link_t                    push_f;
  logic [NODE_W-1:0]        popped;
  logic [1:0]               status;
  logic [COUNT_W-1:0]       count;
  logic [MAXG_W-1:0]        max_gain;
  logic [ROW_W-1:0]         row;

  // shared divider
  logic signed [GAIN_W-1:0] div_src;
  logic [DIV_W-1:0]         div_rem, div_d;
  logic [BKT_W-1:0]         div_q;
  logic [2:0]               div_cnt;

  // sentinel heads live in flops so that clear is immediate
  link_t                    sent_next [MAX_BUCKETS];
  logic [BKT_W-1:0]         sent_idx;
  link_t                    sent_head;
  logic                     top_empty;

  // node memories: links, gain and packed presence rows
  link_t                    link_next_mem [NODE_COUNT];
  link_t                    link_prev_mem [NODE_COUNT];
  logic signed [GAIN_W-1:0] gain_mem [NODE_COUNT];
  logic [ROWS-1:0]          pres_mem [ROWS];

  logic                     rd_en;
  logic [NODE_W-1:0]        rd_addr;
  link_t                    rd_next, rd_prev;
  logic signed [GAIN_W-1:0] rd_gain;
  logic [ROWS-1:0]          rd_pres;

  logic                     nx_we, pv_we, gw_we, pr_we;
  logic [NODE_W-1:0]        nx_addr, pv_addr;
  link_t                    nx_wdata, pv_wdata;
  logic [ROW_W-1:0]         pr_addr;
  logic [ROWS-1:0]          pr_wdata;

  logic                     pres_bit;
  logic                     gain_ok;
  logic signed [GAIN_W:0]   gain_ext, maxg_ext, off_sum;
  logic [GAIN_W-1:0]        div_den;
  logic                     div_small;
  logic                     out_free;
  logic                     gain_cmd;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // only one sentinel is looked at per cycle: the new bucket while pushing, else the top
  assign sent_idx  = (state == S_PUSH_A) ? sb : top;
  assign sent_head = sent_next[sent_idx];
  assign top_empty = (sent_head == sent_code(top));

  assign pres_bit  = rd_pres[nd[ROW_W-1:0]];
  assign gain_cmd  = (op == CMD_INSERT) || (op == CMD_UPDATE);

  // range check of the requested gain against max_gain
  assign gain_ext  = {req_gain[GAIN_W-1], req_gain};
  assign maxg_ext  = signed'({2'b00, max_gain});
  assign gain_ok   = (gain_ext <= maxg_ext) && (gain_ext >= -maxg_ext);

  // bucket arithmetic: offset into 0..2m, divisor 2m+1
  assign off_sum   = {div_src[GAIN_W-1], div_src} + maxg_ext;
  assign div_den   = {max_gain, 1'b1};
  // with 2m+1 no more than MAX_BUCKETS the offset is the bucket itself
  assign div_small = (div_den <= GAIN_W'(MAX_BUCKETS));

  assign rd_addr = (op == CMD_POP) ? sent_head[NODE_W-1:0] : req_node;

  // next state and memory write strobes
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    nx_we      = 1'b0;
    nx_addr    = nd;
    nx_wdata   = push_f;
    pv_we      = 1'b0;
    pv_addr    = nd;
    pv_wdata   = push_f;
    gw_we      = 1'b0;
    pr_we      = 1'b0;
    pr_addr    = nd[NODE_W-1:ROW_W];
    pr_wdata   = rd_pres;
    case (state)
      S_CLEAR: begin
        pr_we    = 1'b1;
        pr_addr  = row;
        pr_wdata = '0;
        if (row == ROW_W'(ROWS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        rd_en = 1'b1;
        if (op > CMD_CLEAR || op == CMD_CLEAR) state_next = S_DONE;
        else if (op == CMD_POP && !top_live) state_next = S_DONE;
        else if (gain_cmd && !gain_ok) state_next = S_DONE;
        else state_next = S_CHECK;
      end
      S_CHECK: begin
        case (op)
          CMD_INSERT: begin
            if (pres_bit) begin
              state_next = S_DONE;
            end else begin
              pr_we                     = 1'b1;
              pr_wdata[nd[ROW_W-1:0]]   = 1'b1;
              gw_we                     = 1'b1;
              state_next                = S_DIV_LOAD;
            end
          end
          CMD_REMOVE: begin
            if (!pres_bit) begin
              state_next = S_DONE;
            end else begin
              pr_we                     = 1'b1;
              pr_wdata[nd[ROW_W-1:0]]   = 1'b0;
              state_next                = S_DETACH;
            end
          end
          CMD_UPDATE: begin
            if (!pres_bit) begin
              state_next = S_DONE;
            end else begin
              gw_we      = 1'b1;
              state_next = S_DIV_LOAD;
            end
          end
          CMD_POP: begin
            pr_we                   = 1'b1;
            pr_wdata[nd[ROW_W-1:0]] = 1'b0;
            state_next              = S_DETACH;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DIV_LOAD: state_next = S_DIV_RUN;
      S_DIV_RUN: begin
        if (div_cnt == 3'd0) state_next = S_ROUTE;
      end
      S_ROUTE: begin
        if (op == CMD_INSERT) state_next = S_PUSH_A;
        else if (op == CMD_UPDATE) begin
          if (phase_old) state_next = S_DIV_LOAD;
          else if (div_q == ob) state_next = S_DONE;
          else state_next = S_DETACH;
        end else state_next = S_DONE;
      end
      S_DETACH: begin
        // next[prev] = next, prev[next] = prev; sentinel prev links are never read
        nx_we    = !rd_prev[LINK_W-1];
        nx_addr  = rd_prev[NODE_W-1:0];
        nx_wdata = rd_next;
        pv_we    = !rd_next[LINK_W-1];
        pv_addr  = rd_next[NODE_W-1:0];
        pv_wdata = rd_prev;
        state_next = (op == CMD_UPDATE) ? S_PUSH_A : S_SETTLE;
      end
      S_PUSH_A: begin
        nx_we    = 1'b1;
        nx_addr  = nd;
        nx_wdata = sent_head;
        pv_we    = 1'b1;
        pv_addr  = nd;
        pv_wdata = sent_code(sb);
        state_next = S_PUSH_B;
      end
      S_PUSH_B: begin
        pv_we    = !push_f[LINK_W-1];
        pv_addr  = push_f[NODE_W-1:0];
        pv_wdata = {1'b0, nd};
        if (!top_live || sb > top || op == CMD_INSERT) state_next = S_DONE;
        else state_next = S_SETTLE;
      end
      S_SETTLE: begin
        if (!(top_live && top_empty)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = (op == CMD_CLEAR) ? S_CLEAR : S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
    // a max_gain write changes the bucket mapping, so the queue restarts empty
    if (cfg_valid) state_next = S_CLEAR;
  end

  // memories
  always_ff @(posedge clk) begin
    if (nx_we) link_next_mem[nx_addr] <= nx_wdata;
    if (pv_we) link_prev_mem[pv_addr] <= pv_wdata;
    if (gw_we) gain_mem[nd] <= req_gain;
    if (pr_we) pres_mem[pr_addr] <= pr_wdata;
    if (rd_en) begin
      rd_next <= link_next_mem[rd_addr];
      rd_prev <= link_prev_mem[rd_addr];
      rd_gain <= gain_mem[rd_addr];
      rd_pres <= pres_mem[rd_addr[NODE_W-1:ROW_W]];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      top_live  <= 1'b0;
      top       <= '0;
      count     <= '0;
      max_gain  <= '0;
      out_valid <= 1'b0;
      for (int b = 0; b < MAX_BUCKETS; b++) sent_next[b] <= sent_code(BKT_W'(b));
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: row <= row + 1'b1;
        S_IDLE: begin
          if (in_valid) begin
            op        <= in_data.cmd;
            req_node  <= in_data.node;
            req_gain  <= in_data.gain;
            popped    <= '0;
            status    <= STAT_DONE;
            phase_old <= 1'b0;
          end
        end
        S_READ: begin
          nd <= rd_addr;
          if (op == CMD_CLEAR) begin
            for (int b = 0; b < MAX_BUCKETS; b++) sent_next[b] <= sent_code(BKT_W'(b));
            top_live <= 1'b0;
            count    <= '0;
            row      <= '0;
          end else if (op > CMD_CLEAR) status <= STAT_IGNORED;
          else if (op == CMD_POP && !top_live) status <= STAT_EMPTY;
          else if (gain_cmd && !gain_ok) status <= STAT_RANGE;
        end
        S_CHECK: begin
          case (op)
            CMD_INSERT: begin
              if (pres_bit) status <= STAT_IGNORED;
              else div_src <= req_gain;
            end
            CMD_REMOVE: begin
              if (!pres_bit) status <= STAT_IGNORED;
              else count <= count - 1'b1;
            end
            CMD_UPDATE: begin
              if (!pres_bit) status <= STAT_IGNORED;
              else begin
                div_src   <= rd_gain;
                phase_old <= 1'b1;
              end
            end
            CMD_POP: begin
              count  <= count - 1'b1;
              popped <= nd;
            end
            default: status <= STAT_IGNORED;
          endcase
        end
        S_DIV_LOAD: begin
          div_rem <= {off_sum[GAIN_W-1:0], {BKT_W{1'b0}}};
          div_d   <= {1'b0, div_den, {(BKT_W-1){1'b0}}};
          if (div_small) begin
            div_q   <= off_sum[BKT_W-1:0];
            div_cnt <= 3'd0;
          end else begin
            div_q   <= '0;
            div_cnt <= 3'(BKT_W);
          end
        end
        S_DIV_RUN: begin
          // restoring division, one quotient bit per step
          if (div_cnt != 3'd0) begin
            if (div_rem >= div_d) begin
              div_rem <= div_rem - div_d;
              div_q   <= {div_q[BKT_W-2:0], 1'b1};
            end else begin
              div_q   <= {div_q[BKT_W-2:0], 1'b0};
            end
            div_d   <= div_d >> 1;
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_ROUTE: begin
          if (op == CMD_INSERT) begin
            sb    <= div_q;
            count <= count + 1'b1;
          end else if (phase_old) begin
            ob        <= div_q;
            phase_old <= 1'b0;
            div_src   <= req_gain;
          end else begin
            sb <= div_q;
          end
        end
        S_DETACH: begin
          if (rd_prev[LINK_W-1]) sent_next[rd_prev[BKT_W-1:0]] <= rd_next;
        end
        S_PUSH_A: push_f <= sent_head;
        S_PUSH_B: begin
          sent_next[sb] <= {1'b0, nd};
          if (!top_live || sb > top) begin
            top      <= sb;
            top_live <= 1'b1;
          end
        end
        S_SETTLE: begin
          // walk down past empty buckets, one per cycle
          if (top_live && top_empty) begin
            if (top == '0) top_live <= 1'b0;
            else top <= top - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.popped_node <= popped;
            out_data.status      <= status;
            out_data.count       <= count;
          end
        end
        default: ;
      endcase
      if (cfg_valid) begin
        max_gain <= cfg_data;
        for (int b = 0; b < MAX_BUCKETS; b++) sent_next[b] <= sent_code(BKT_W'(b));
        top_live <= 1'b0;
        count    <= '0;
        row      <= '0;
      end
    end
  end

  // queue never holds more nodes than ids exist
  assert property (@(posedge clk) disable iff (rst) count <= COUNT_W'(NODE_COUNT))
    else $error("queued count beyond node count");

  // between transactions an empty top marker means no nodes queued and vice versa
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((count == '0) == !top_live))
    else $error("top marker disagrees with queued count");

  // between transactions the top bucket holds at least one node
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && top_live) |-> !top_empty)
    else $error("top bucket empty while marked live");

  // a pop on an empty queue returns node zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STAT_EMPTY) |-> (out_data.popped_node == '0))
    else $error("empty pop returned a node");

endmodule

// File: tb/sv/gain_bucket_priority_queue_tb.sv
// gain_bucket_priority_queue_tb: self-checking bench of the gain bucket priority queue
// depends on gbq_pkg and gain_bucket_priority_queue; a golden model predicts each result
`timescale 1ns / 1ps
module gain_bucket_priority_queue_tb;
  import gbq_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SENT0 = NODE_COUNT;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  gbq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gbq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;

  always #10 clk = ~clk;

  gain_bucket_priority_queue i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // golden copy of the queue: rings of nodes behind one sentinel per bucket
  int unsigned ring_next [NODE_COUNT+MAX_BUCKETS];
  int unsigned ring_prev [NODE_COUNT+MAX_BUCKETS];
  bit          queued [NODE_COUNT];
  int          stored_gain [NODE_COUNT];
  int          highest_bucket;
  int unsigned nodes_queued;
  int unsigned gain_limit;

  gbq_out_t pending_results[$];
  int       error_count = 0;
  int       idle_cycles = 0;

  function automatic int unsigned bucket_count();
    int unsigned n;
    n = 2 * gain_limit + 1;
    return (n > MAX_BUCKETS) ? MAX_BUCKETS : n;
  endfunction

  function automatic int unsigned bucket_for(int g);
    longint unsigned off;
    off = longint'(g) + gain_limit;
    return (off * bucket_count()) / (2 * gain_limit + 1);
  endfunction

  function automatic void ring_push(int unsigned s, int unsigned n);
    ring_next[n] = ring_next[s];
    ring_prev[n] = s;
    ring_prev[ring_next[s]] = n;
    ring_next[s] = n;
  endfunction

  function automatic void ring_unlink(int unsigned n);
    ring_prev[ring_next[n]] = ring_prev[n];
    ring_next[ring_prev[n]] = ring_next[n];
    ring_next[n] = n;
    ring_prev[n] = n;
  endfunction

  function automatic void drop_empty_tops();
    while (highest_bucket >= 0 &&
           ring_next[SENT0+highest_bucket] == SENT0 + highest_bucket)
      highest_bucket--;
  endfunction

  function automatic void empty_queue();
    for (int n = 0; n < NODE_COUNT; n++) queued[n] = 1'b0;
    for (int b = 0; b < MAX_BUCKETS; b++) begin
      ring_next[SENT0+b] = SENT0 + b;
      ring_prev[SENT0+b] = SENT0 + b;
    end
    highest_bucket = -1;
    nodes_queued = 0;
  endfunction

  // works out the result of one command and moves the golden queue along
  function automatic gbq_out_t queue_outcome(gbq_in_t t);
    gbq_out_t r;
    int g;
    bit in_range;
    int unsigned n, ob, nb;
    r = '0;
    g = int'(t.gain);
    in_range = (g <= int'(gain_limit)) && (g >= -int'(gain_limit));
    n = t.node;
    r.status = STAT_DONE;
    if (t.cmd == CMD_POP) begin
      if (highest_bucket < 0) r.status = STAT_EMPTY;
      else begin
        n = ring_next[SENT0+highest_bucket];
        ring_unlink(n);
        queued[n] = 1'b0;
        nodes_queued--;
        r.popped_node = n;
        drop_empty_tops();
      end
    end else if (t.cmd == CMD_CLEAR) begin
      empty_queue();
    end else if (t.cmd > CMD_CLEAR) begin
      r.status = STAT_IGNORED;
    end else if ((t.cmd == CMD_INSERT || t.cmd == CMD_UPDATE) && !in_range) begin
      r.status = STAT_RANGE;
    end else if (t.cmd == CMD_INSERT) begin
      if (queued[n]) r.status = STAT_IGNORED;
      else begin
        nb = bucket_for(g);
        queued[n] = 1'b1;
        stored_gain[n] = g;
        ring_push(SENT0 + nb, n);
        nodes_queued++;
        if (int'(nb) > highest_bucket) highest_bucket = nb;
      end
    end else if (t.cmd == CMD_REMOVE) begin
      if (!queued[n]) r.status = STAT_IGNORED;
      else begin
        ring_unlink(n);
        queued[n] = 1'b0;
        nodes_queued--;
        drop_empty_tops();
      end
    end else begin
      if (!queued[n]) r.status = STAT_IGNORED;
      else begin
        ob = bucket_for(stored_gain[n]);
        nb = bucket_for(g);
        stored_gain[n] = g;
        // a node that changes bucket goes to the front of the new one
        if (ob != nb) begin
          ring_unlink(n);
          ring_push(SENT0 + nb, n);
          if (int'(nb) > highest_bucket) highest_bucket = nb;
          else drop_empty_tops();
        end
      end
    end
    r.count = nodes_queued[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result side: compare each accepted transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          gbq_out_t w;
          w = pending_results.pop_front();
          if (out_data.popped_node !== w.popped_node)
            report_mismatch("popped_node", out_data.popped_node, w.popped_node);
          if (out_data.status !== w.status)
            report_mismatch("status", out_data.status, w.status);
          if (out_data.count !== w.count)
            report_mismatch("count", out_data.count, w.count);
        end
      end
    end
  end

  // receiver stall pattern: runs of free flow and runs of random stalls
  int stall_mode = 0;
  int stall_run = 0;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(5, 60);
    end
    stall_run--;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 1) == 0);
      end
    endcase
  end

  // watchdog: cycles with nothing accepted on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[gain_bucket_priority_queue] ERROR");
      $finish;
    end
  end

  int burst_left = 0;

  // one command transaction; known answer checked as well when given
  task automatic send_command(gbq_in_t t, bit check_known, gbq_out_t known);
    gbq_out_t w;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_data <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    w = queue_outcome(t);
    if (check_known && w !== known) report_mismatch("known answer row", w, known);
    pending_results.push_back(w);
    @(negedge clk);
  endtask

  task automatic set_gain_limit(logic [14:0] v);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (120) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    gain_limit = v;
    empty_queue();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic gbq_in_t make_cmd(logic [2:0] c, int n, int g);
    gbq_in_t t;
    t.cmd = c;
    t.node = n[NODE_W-1:0];
    t.gain = g[GAIN_W-1:0];
    return t;
  endfunction

  function automatic gbq_out_t make_res(int p, logic [1:0] s, int c);
    gbq_out_t r;
    r.popped_node = p[NODE_W-1:0];
    r.status = s;
    r.count = c[COUNT_W-1:0];
    return r;
  endfunction

  typedef struct {
    gbq_in_t  stim;
    bit       known;
    gbq_out_t answer;
  } directed_row_t;

  directed_row_t directed_rows[$];

  // random command mix over nodes 0..pool; a small pool makes hits on present nodes common
  task automatic random_phase(int items, int pool);
    gbq_in_t t;
    int pick, g, lim;
    lim = gain_limit;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) g = $signed(16'($urandom));
      else g = $urandom_range(0, 2 * lim) - lim;
      if (pick < 38) t = make_cmd(CMD_INSERT, $urandom_range(0, pool), g);
      else if (pick < 52) t = make_cmd(CMD_REMOVE, $urandom_range(0, pool), g);
      else if (pick < 72) t = make_cmd(CMD_UPDATE, $urandom_range(0, pool), g);
      else if (pick < 94) t = make_cmd(CMD_POP, $urandom, $urandom);
      else if (pick < 96) t = make_cmd(CMD_CLEAR, $urandom, $urandom);
      else t = make_cmd(3'($urandom_range(5, 7)), $urandom, $urandom);
      send_command(t, 1'b0, '0);
    end
  endtask

  initial begin
    gain_limit = 0;
    empty_queue();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table at max_gain 0: one bucket, then extremes and error codes
    directed_rows.push_back('{make_cmd(CMD_POP, 0, 0), 1, make_res(0, STAT_EMPTY, 0)});
    directed_rows.push_back('{make_cmd(CMD_INSERT, 1023, 0), 1, make_res(0, STAT_DONE, 1)});
    directed_rows.push_back('{make_cmd(CMD_INSERT, 1023, 0), 1,
                              make_res(0, STAT_IGNORED, 1)});
    directed_rows.push_back('{make_cmd(CMD_INSERT, 5, 1), 1, make_res(0, STAT_RANGE, 1)});
    directed_rows.push_back('{make_cmd(CMD_INSERT, 5, -32768), 1,
                              make_res(0, STAT_RANGE, 1)});
    directed_rows.push_back('{make_cmd(CMD_UPDATE, 1023, -1), 1,
                              make_res(0, STAT_RANGE, 1)});
    directed_rows.push_back('{make_cmd(CMD_INSERT, 0, 0), 1, make_res(0, STAT_DONE, 2)});
    directed_rows.push_back('{make_cmd(CMD_POP, 0, 0), 1, make_res(0, STAT_DONE, 1)});
    directed_rows.push_back('{make_cmd(CMD_REMOVE, 0, 0), 1,
                              make_res(0, STAT_IGNORED, 1)});
    directed_rows.push_back('{make_cmd(CMD_UPDATE, 0, 0), 1,
                              make_res(0, STAT_IGNORED, 1)});
    directed_rows.push_back('{make_cmd(3'd7, 3, 0), 1, make_res(0, STAT_IGNORED, 1)});
    directed_rows.push_back('{make_cmd(3'd5, 3, 0), 1, make_res(0, STAT_IGNORED, 1)});
    directed_rows.push_back('{make_cmd(CMD_CLEAR, 0, 0), 1, make_res(0, STAT_DONE, 0)});
    foreach (directed_rows[i])
      send_command(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].answer);

    // full range: extreme gains, same-bucket update and bucket moves
    set_gain_limit(15'h7fff);
    send_command(make_cmd(CMD_INSERT, 10, 32767), 1'b0, '0);
    send_command(make_cmd(CMD_INSERT, 11, -32767), 1'b0, '0);
    send_command(make_cmd(CMD_INSERT, 12, 32760), 1'b0, '0);
    send_command(make_cmd(CMD_UPDATE, 12, 32766), 1'b0, '0);
    send_command(make_cmd(CMD_UPDATE, 11, 32000), 1'b0, '0);
    send_command(make_cmd(CMD_UPDATE, 10, -32767), 1'b0, '0);
    send_command(make_cmd(CMD_REMOVE, 12, 0), 1'b0, '0);
    send_command(make_cmd(CMD_POP, 0, 0), 1'b0, '0);
    send_command(make_cmd(CMD_POP, 0, 0), 1'b0, '0);
    send_command(make_cmd(CMD_POP, 0, 0), 1'b0, '0);

    // random phases over several settings; all bits of node reached by the wide pool
    set_gain_limit(15'd1);
    random_phase(150, 15);
    set_gain_limit(15'd0);
    random_phase(100, 15);
    set_gain_limit(15'd20);
    random_phase(200, 40);
    set_gain_limit(15'h7fff);
    random_phase(300, 1023);
    set_gain_limit(15'd300);
    random_phase(250, 60);

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("[gain_bucket_priority_queue] OK");
    else
      $display("[gain_bucket_priority_queue] ERROR");
    $finish;
  end

endmodule
